FILE: hdl/tmpg_pkg.sv
package tmpg_pkg;

	localparam int MAG_W      = 23;
	localparam int DIST_W     = 24;
	localparam int RATE_W     = 16;
	localparam int VEL_W      = 17;
	localparam int HDG_W      = 17;
	localparam int STEP_W     = 20;
	localparam int GAIN_FRAC  = 8;
	localparam int DRV_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int DIV_NUM_W  = 56;
	localparam int DIV_DEN_W  = 17;
	localparam int DIV_CNT_W  = 6;
	localparam int ROOT_W     = DIV_NUM_W / 2;
	localparam int SQRT_CNT_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_RATE     = 3'd0,
		REG_DECEL_RATE     = 3'd1,
		REG_MAX_VELOCITY   = 3'd2,
		REG_VELOCITY_SCALE = 3'd3,
		REG_HEADING_GAIN   = 3'd4
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_PLAN_MAG,
		OP_PLAN_MUL,
		OP_DIV_PEAK,
		OP_SQRT_GO,
		OP_PEAK,
		OP_CRUISE_SQ,
		OP_DIV_ACC_DIST,
		OP_SET_ACC_DIST,
		OP_DIV_DEC_DIST,
		OP_SET_REST,
		OP_DIV_HOLD,
		OP_SET_HOLD,
		OP_DIV_ACC_STEPS,
		OP_SET_ACC_STEPS,
		OP_DIV_DEC_STEPS,
		OP_SET_DEC_STEPS,
		OP_IDLE_PT,
		OP_ACC_V,
		OP_ACC_D,
		OP_HOLD_PT,
		OP_STEP_CLR,
		OP_STEP_ONE,
		OP_DEC_V,
		OP_DEC_SQ,
		OP_DIV_REM,
		OP_DEC_D,
		OP_FIN_PT,
		OP_DRV_MUL,
		OP_DRV_OUT
	} op_t;

	typedef struct packed {
		logic take;
		op_t  op;
	} tmpg_cmd_t;

	typedef struct packed {
		logic lt_accel;
		logic lt_hold;
		logic lt_decel;
		logic trap;
		logic cruise_zero;
		logic div_done;
		logic sqrt_done;
	} tmpg_sts_t;

	function automatic logic [STEP_W-1:0] sat_count(input logic [DIV_NUM_W-1:0] x);
		if (x > DIV_NUM_W'({STEP_W{1'b1}}))
			return {STEP_W{1'b1}};
		return x[STEP_W-1:0];
	endfunction

endpackage

FILE: hdl/trapezoid_motion_profile_core.sv
// Start word: plans the move with the shared one-bit-per-cycle divider and the square root;
// a trapezoid profile needs three divisions more than a triangle profile does.
// Tick word: idle, accel, hold and final points need no division, a decel point needs one;
// one word is worked on at a time.
// A start word produces no result word; every tick word produces exactly one.
// Reset (arst_n low, asynchronous) idles the block and loads the register defaults.
module trapezoid_motion_profile_core import tmpg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [RATE_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic signed [DIST_W-1:0] move_distance,
	input  logic [RATE_W-1:0]        cruise_velocity,
	input  logic signed [HDG_W-1:0]  heading,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VEL_W-1:0]  velocity_setpoint,
	output logic signed [DIST_W-1:0] distance_setpoint,
	output logic signed [DRV_W-1:0]  left_drive,
	output logic signed [DRV_W-1:0]  right_drive,
	output logic                     profile_done
);

	tmpg_cmd_t cmd;
	tmpg_sts_t sts;

	tmpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tmpg_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.cmd               (cmd),
		.sts               (sts),
		.move_distance     (move_distance),
		.cruise_velocity   (cruise_velocity),
		.heading           (heading),
		.velocity_setpoint (velocity_setpoint),
		.distance_setpoint (distance_setpoint),
		.left_drive        (left_drive),
		.right_drive       (right_drive),
		.profile_done      (profile_done)
	);

endmodule

FILE: hdl/tmpg_div.sv
module tmpg_div import tmpg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_NUM_W-1:0] quo,
	output logic                 done
);

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_NUM_W);

	logic [DIV_NUM_W-1:0] n_q;
	logic [DIV_DEN_W-1:0] r_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   shifted;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	// One quotient bit per cycle, restoring, quotient shifts in behind the numerator.
	assign shifted = {r_q, n_q[DIV_NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CNT_W'(1));
			if (start)
				cnt_q <= DIV_STEPS;
			else if (cnt_q != '0)
				cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			r_q   <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			r_q <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
			n_q <= {n_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign quo  = n_q;
	assign done = done_q;

endmodule

FILE: hdl/tmpg_sqrt.sv
module tmpg_sqrt import tmpg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] x,
	output logic [ROOT_W-1:0]    root,
	output logic                 done
);

	localparam logic [SQRT_CNT_W-1:0] SQRT_STEPS = SQRT_CNT_W'(ROOT_W);

	logic [DIV_NUM_W-1:0]  x_q;
	logic [ROOT_W+1:0]     rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  done_q;
	logic [ROOT_W+3:0]     r2;
	logic [ROOT_W+3:0]     trial;
	logic                  ge;

	// Two radicand bits per cycle, one root bit out.
	assign r2    = {rem_q, x_q[DIV_NUM_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == SQRT_CNT_W'(1));
			if (start)
				cnt_q <= SQRT_STEPS;
			else if (cnt_q != '0)
				cnt_q <= cnt_q - SQRT_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? (ROOT_W+2)'(r2 - trial) : r2[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			x_q    <= {x_q[DIV_NUM_W-3:0], 2'b00};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

FILE: hdl/tmpg_datapath.sv
module tmpg_datapath import tmpg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [RATE_W-1:0]        cfg_data,
	input  tmpg_cmd_t                cmd,
	output tmpg_sts_t                sts,
	input  logic signed [DIST_W-1:0] move_distance,
	input  logic [RATE_W-1:0]        cruise_velocity,
	input  logic signed [HDG_W-1:0]  heading,
	output logic signed [VEL_W-1:0]  velocity_setpoint,
	output logic signed [DIST_W-1:0] distance_setpoint,
	output logic signed [DRV_W-1:0]  left_drive,
	output logic signed [DRV_W-1:0]  right_drive,
	output logic                     profile_done
);

	function automatic logic signed [DRV_W-1:0] sat_drive(input logic signed [35:0] x);
		if (x > 36'(signed'({1'b0, {(DRV_W-1){1'b1}}})))
			return {1'b0, {(DRV_W-1){1'b1}}};
		if (x < -36'(signed'({1'b0, {(DRV_W-1){1'b1}}})) - 36'sd1)
			return {1'b1, {(DRV_W-1){1'b0}}};
		return x[DRV_W-1:0];
	endfunction

	// Configuration
	logic [RATE_W-1:0] acc_q, dec_q, vmax_q, vscale_q, hgain_q;
	logic [RATE_W-1:0] a_eff, d_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= 16'd256;
			dec_q    <= 16'd256;
			vmax_q   <= 16'hFFFF;
			vscale_q <= 16'd256;
			hgain_q  <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACCEL_RATE:     acc_q    <= cfg_data;
				REG_DECEL_RATE:     dec_q    <= cfg_data;
				REG_MAX_VELOCITY:   vmax_q   <= cfg_data;
				REG_VELOCITY_SCALE: vscale_q <= cfg_data;
				REG_HEADING_GAIN:   hgain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// A rate of zero behaves as one.
	assign a_eff = (acc_q == '0) ? RATE_W'(1) : acc_q;
	assign d_eff = (dec_q == '0) ? RATE_W'(1) : dec_q;

	// Input word and planned move
	logic [DIST_W-1:0]        it_dist_q;
	logic [RATE_W-1:0]        it_cruise_q;
	logic signed [HDG_W-1:0]  it_hdg_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     rev_q;
	logic [RATE_W-1:0]        cruise_q;
	logic signed [HDG_W-1:0]  sthdg_q;
	logic [DIV_NUM_W-1:0]     prod_q;
	logic [RATE_W-1:0]        pk_q;
	logic [31:0]              ad_q;
	logic [MAG_W-1:0]         adist_q;
	logic [MAG_W-1:0]         rest_q;
	logic [STEP_W-1:0]        hold_q, as_q, ds_q, step_q;
	logic [RATE_W-1:0]        v_q;
	logic [MAG_W-1:0]         dist_q;
	logic                     idle_q;
	logic                     done_q;
	logic signed [VEL_W-1:0]  vs_s1;
	logic signed [DIST_W-1:0] ds_s1;
	logic signed [33:0]       scl_s1;
	logic signed [34:0]       cmp_s1;

	logic [DIST_W-1:0]     absd;
	logic [MAG_W-1:0]      mag_c;
	logic [RATE_W-1:0]     cruise_c;
	logic [38:0]           mul_mag;
	logic [54:0]           mul_plan;
	logic [RATE_W-1:0]     mul_a;
	logic [35:0]           mul_step;
	logic [RATE_W-1:0]     sq_a;
	logic [31:0]           mul_sq;
	logic [36:0]           acc_t;
	logic [36:0]           hold_t;
	logic [32:0]           both_d;
	logic [RATE_W-1:0]     v_dec;
	logic signed [VEL_W-1:0]  vs_c;
	logic signed [DIST_W-1:0] ds_c;
	logic signed [HDG_W:0]    err_c;
	logic signed [25:0]    scaled;
	logic signed [26:0]    comp;
	logic signed [35:0]    sum_l, sum_r;

	logic                  div_start, sqrt_start;
	logic [DIV_NUM_W-1:0]  div_num, quo;
	logic [DIV_DEN_W-1:0]  div_den;
	logic                  div_done;
	logic [ROOT_W-1:0]     root;
	logic                  sqrt_done;
	logic                  trap_c;

	assign absd     = it_dist_q[DIST_W-1] ? (~it_dist_q + DIST_W'(1)) : it_dist_q;
	assign mag_c    = absd[DIST_W-1] ? {MAG_W{1'b1}} : absd[MAG_W-1:0];
	assign cruise_c = (it_cruise_q > vmax_q) ? vmax_q : it_cruise_q;
	assign mul_mag  = mag_c * a_eff;
	assign mul_plan = prod_q[38:0] * d_eff;

	// One shared step multiplier for the per-point products.
	always_comb begin
		unique case (cmd.op)
			OP_ACC_V:   mul_a = a_eff;
			OP_DEC_V:   mul_a = d_eff;
			OP_ACC_D:   mul_a = v_q;
			default:    mul_a = pk_q;
		endcase
	end
	assign mul_step = mul_a * step_q;

	assign sq_a   = (cmd.op == OP_DEC_SQ) ? v_q : cruise_q;
	assign mul_sq = sq_a * sq_a;

	assign acc_t  = (37'(mul_step) + 37'd1) >> 1;
	assign hold_t = 37'(adist_q) + 37'(mul_step);
	assign both_d = 33'(ad_q) + 33'(quo[31:0]);
	assign v_dec  = (mul_step >= 36'(pk_q)) ? '0 : pk_q - mul_step[RATE_W-1:0];
	assign trap_c = root > ROOT_W'(cruise_q);

	always_comb begin
		div_start = 1'b1;
		div_num   = prod_q;
		div_den   = 17'(a_eff) + 17'(d_eff);
		unique case (cmd.op)
			OP_DIV_PEAK: begin
				div_num = prod_q;
				div_den = 17'(a_eff) + 17'(d_eff);
			end
			OP_DIV_ACC_DIST: begin
				div_num = DIV_NUM_W'(prod_q[31:0]) + DIV_NUM_W'(a_eff);
				div_den = {a_eff, 1'b0};
			end
			OP_DIV_DEC_DIST, OP_DIV_REM: begin
				div_num = DIV_NUM_W'(prod_q[31:0]) + DIV_NUM_W'(d_eff);
				div_den = {d_eff, 1'b0};
			end
			OP_DIV_HOLD: begin
				div_num = DIV_NUM_W'(rest_q) + DIV_NUM_W'(cruise_q) - DIV_NUM_W'(1);
				div_den = DIV_DEN_W'(cruise_q);
			end
			OP_DIV_ACC_STEPS: begin
				div_num = DIV_NUM_W'(pk_q) + DIV_NUM_W'(a_eff) - DIV_NUM_W'(1);
				div_den = DIV_DEN_W'(a_eff);
			end
			OP_DIV_DEC_STEPS: begin
				div_num = DIV_NUM_W'(pk_q) + DIV_NUM_W'(d_eff) - DIV_NUM_W'(1);
				div_den = DIV_DEN_W'(d_eff);
			end
			default: div_start = 1'b0;
		endcase
	end

	assign sqrt_start = (cmd.op == OP_SQRT_GO);

	tmpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.done   (div_done)
	);

	// The root is taken of the quotient that the divider still holds.
	tmpg_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (quo),
		.root   (root),
		.done   (sqrt_done)
	);

	// Signed setpoints and the steering error.
	assign vs_c  = rev_q ? -VEL_W'({1'b0, v_q}) : VEL_W'({1'b0, v_q});
	assign ds_c  = rev_q ? -DIST_W'({1'b0, dist_q}) : DIST_W'({1'b0, dist_q});
	assign err_c = (HDG_W+1)'(it_hdg_q) - (HDG_W+1)'(sthdg_q);

	// Arithmetic shifts give the floor of the Q8.8 products.
	assign scaled = 26'(scl_s1 >>> GAIN_FRAC);
	assign comp   = 27'(cmp_s1 >>> GAIN_FRAC);
	assign sum_l  = 36'(scaled) - 36'(comp);
	assign sum_r  = 36'(scaled) + 36'(comp);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			it_dist_q   <= move_distance;
			it_cruise_q <= cruise_velocity;
			it_hdg_q    <= heading;
		end
		unique case (cmd.op)
			OP_PLAN_MAG: begin
				mag_q    <= mag_c;
				rev_q    <= it_dist_q[DIST_W-1];
				cruise_q <= cruise_c;
				sthdg_q  <= it_hdg_q;
				prod_q   <= DIV_NUM_W'(mul_mag);
			end
			OP_PLAN_MUL:  prod_q <= {mul_plan, 1'b0};
			OP_PEAK: begin
				pk_q    <= trap_c ? cruise_q : root[RATE_W-1:0];
				hold_q  <= '0;
				adist_q <= '0;
			end
			OP_CRUISE_SQ: prod_q <= DIV_NUM_W'(mul_sq);
			OP_SET_ACC_DIST: begin
				ad_q    <= quo[31:0];
				adist_q <= (quo > DIV_NUM_W'(mag_q)) ? mag_q : quo[MAG_W-1:0];
			end
			OP_SET_REST:
				rest_q <= (both_d < 33'(mag_q)) ? mag_q - both_d[MAG_W-1:0] : '0;
			OP_SET_HOLD:      hold_q <= sat_count(quo + DIV_NUM_W'(1));
			OP_SET_ACC_STEPS: as_q   <= sat_count(quo);
			OP_SET_DEC_STEPS: ds_q   <= sat_count(quo);
			OP_IDLE_PT: begin
				v_q    <= '0;
				dist_q <= '0;
			end
			OP_ACC_V:
				v_q <= (mul_step > 36'(pk_q)) ? pk_q : mul_step[RATE_W-1:0];
			OP_ACC_D:
				dist_q <= (acc_t > 37'(mag_q)) ? mag_q : acc_t[MAG_W-1:0];
			OP_HOLD_PT: begin
				v_q    <= pk_q;
				dist_q <= (hold_t > 37'(mag_q)) ? mag_q : hold_t[MAG_W-1:0];
			end
			OP_DEC_V:  v_q    <= v_dec;
			OP_DEC_SQ: prod_q <= DIV_NUM_W'(mul_sq);
			OP_DEC_D:
				dist_q <= (quo >= DIV_NUM_W'(mag_q)) ? '0 : mag_q - quo[MAG_W-1:0];
			OP_FIN_PT: begin
				v_q    <= '0;
				dist_q <= mag_q;
			end
			OP_DRV_MUL: begin
				vs_s1  <= vs_c;
				ds_s1  <= ds_c;
				scl_s1 <= vs_c * signed'({1'b0, vscale_q});
				cmp_s1 <= err_c * signed'({1'b0, hgain_q});
			end
			OP_DRV_OUT: begin
				velocity_setpoint <= vs_s1;
				distance_setpoint <= ds_s1;
				left_drive        <= idle_q ? '0 : sat_drive(sum_l);
				right_drive       <= idle_q ? '0 : sat_drive(sum_r);
				profile_done      <= done_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			idle_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_SET_DEC_STEPS: step_q <= '0;
				OP_IDLE_PT: begin
					idle_q <= 1'b1;
					done_q <= 1'b1;
				end
				OP_ACC_V, OP_DEC_V: begin
					idle_q <= 1'b0;
					done_q <= 1'b0;
				end
				OP_ACC_D, OP_DEC_D: step_q <= step_q + STEP_W'(1);
				OP_HOLD_PT: begin
					idle_q <= 1'b0;
					done_q <= 1'b0;
					step_q <= step_q + STEP_W'(1);
				end
				OP_STEP_CLR: step_q <= '0;
				OP_STEP_ONE: step_q <= STEP_W'(1);
				OP_FIN_PT: begin
					idle_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign sts.lt_accel    = step_q < as_q;
	assign sts.lt_hold     = step_q < hold_q;
	assign sts.lt_decel    = step_q < ds_q;
	assign sts.trap        = trap_c;
	assign sts.cruise_zero = (cruise_q == '0);
	assign sts.div_done    = div_done;
	assign sts.sqrt_done   = sqrt_done;

endmodule

FILE: hdl/tmpg_ctrl.sv
module tmpg_ctrl import tmpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      req_type,
	output logic      out_valid,
	input  logic      out_ready,
	input  tmpg_sts_t sts,
	output tmpg_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_PLAN_MAG, S_PLAN_MUL, S_DIV_PEAK, S_W_PEAK, S_SQRT, S_W_SQRT,
		S_PEAK, S_CRUISE_SQ, S_DIV_AD, S_W_AD, S_DIV_DD, S_W_DD, S_DIV_HOLD,
		S_W_HOLD, S_DIV_AS, S_W_AS, S_DIV_DS, S_W_DS, S_IDLE_PT, S_TICK,
		S_ACC_D, S_DEC_SQ, S_DEC_DIV, S_W_REM, S_DRV_MUL, S_DRV_OUT
	} state_t;

	typedef enum logic [1:0] {PH_ACC, PH_HOLD, PH_DEC, PH_FIN} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   active_q, active_d;
	logic   out_valid_q;
	logic   take;
	logic   load_out;
	op_t    op;

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;
	assign load_out = (op == OP_DRV_OUT);

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		active_d = active_q;
		op       = OP_NONE;
		unique case (state_q)
			S_IDLE:
				if (take) begin
					if (!req_type)
						state_d = S_PLAN_MAG;
					else if (active_q)
						state_d = S_TICK;
					else
						state_d = S_IDLE_PT;
				end
			S_PLAN_MAG: begin
				op      = OP_PLAN_MAG;
				state_d = S_PLAN_MUL;
			end
			S_PLAN_MUL: begin
				op      = OP_PLAN_MUL;
				state_d = S_DIV_PEAK;
			end
			S_DIV_PEAK: begin
				op      = OP_DIV_PEAK;
				state_d = S_W_PEAK;
			end
			S_W_PEAK: if (sts.div_done) state_d = S_SQRT;
			S_SQRT: begin
				op      = OP_SQRT_GO;
				state_d = S_W_SQRT;
			end
			S_W_SQRT: if (sts.sqrt_done) state_d = S_PEAK;
			S_PEAK: begin
				op      = OP_PEAK;
				state_d = (sts.trap && !sts.cruise_zero) ? S_CRUISE_SQ : S_DIV_AS;
			end
			S_CRUISE_SQ: begin
				op      = OP_CRUISE_SQ;
				state_d = S_DIV_AD;
			end
			S_DIV_AD: begin
				op      = OP_DIV_ACC_DIST;
				state_d = S_W_AD;
			end
			S_W_AD:
				if (sts.div_done) begin
					op      = OP_SET_ACC_DIST;
					state_d = S_DIV_DD;
				end
			S_DIV_DD: begin
				op      = OP_DIV_DEC_DIST;
				state_d = S_W_DD;
			end
			S_W_DD:
				if (sts.div_done) begin
					op      = OP_SET_REST;
					state_d = S_DIV_HOLD;
				end
			S_DIV_HOLD: begin
				op      = OP_DIV_HOLD;
				state_d = S_W_HOLD;
			end
			S_W_HOLD:
				if (sts.div_done) begin
					op      = OP_SET_HOLD;
					state_d = S_DIV_AS;
				end
			S_DIV_AS: begin
				op      = OP_DIV_ACC_STEPS;
				state_d = S_W_AS;
			end
			S_W_AS:
				if (sts.div_done) begin
					op      = OP_SET_ACC_STEPS;
					state_d = S_DIV_DS;
				end
			S_DIV_DS: begin
				op      = OP_DIV_DEC_STEPS;
				state_d = S_W_DS;
			end
			S_W_DS:
				if (sts.div_done) begin
					op       = OP_SET_DEC_STEPS;
					active_d = 1'b1;
					phase_d  = PH_ACC;
					state_d  = S_IDLE;
				end
			S_IDLE_PT: begin
				op      = OP_IDLE_PT;
				state_d = S_DRV_MUL;
			end
			// Empty phases are skipped one per cycle until a point is produced.
			S_TICK:
				unique case (phase_q)
					PH_ACC:
						if (sts.lt_accel) begin
							op      = OP_ACC_V;
							state_d = S_ACC_D;
						end else begin
							op      = OP_STEP_CLR;
							phase_d = PH_HOLD;
						end
					PH_HOLD:
						if (sts.lt_hold) begin
							op      = OP_HOLD_PT;
							state_d = S_DRV_MUL;
						end else begin
							op      = OP_STEP_ONE;
							phase_d = PH_DEC;
						end
					PH_DEC:
						if (sts.lt_decel) begin
							op      = OP_DEC_V;
							state_d = S_DEC_SQ;
						end else begin
							phase_d = PH_FIN;
						end
					PH_FIN: begin
						op       = OP_FIN_PT;
						active_d = 1'b0;
						phase_d  = PH_ACC;
						state_d  = S_DRV_MUL;
					end
				endcase
			S_ACC_D: begin
				op      = OP_ACC_D;
				state_d = S_DRV_MUL;
			end
			S_DEC_SQ: begin
				op      = OP_DEC_SQ;
				state_d = S_DEC_DIV;
			end
			S_DEC_DIV: begin
				op      = OP_DIV_REM;
				state_d = S_W_REM;
			end
			S_W_REM:
				if (sts.div_done) begin
					op      = OP_DEC_D;
					state_d = S_DRV_MUL;
				end
			S_DRV_MUL: begin
				op      = OP_DRV_MUL;
				state_d = S_DRV_OUT;
			end
			S_DRV_OUT:
				if (!out_valid_q || out_ready) begin
					op      = OP_DRV_OUT;
					state_d = S_IDLE;
				end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_ACC;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			active_q <= active_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign cmd.take  = take;
	assign cmd.op    = op;

endmodule

FILE: hdl/tmpg_checker.sv
module tmpg_checker import tmpg_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_we,
	input logic [CFG_IDX_W-1:0]     cfg_index,
	input logic [RATE_W-1:0]        cfg_data,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     req_type,
	input logic signed [DIST_W-1:0] move_distance,
	input logic [RATE_W-1:0]        cruise_velocity,
	input logic signed [HDG_W-1:0]  heading,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [VEL_W-1:0]  velocity_setpoint,
	input logic signed [DIST_W-1:0] distance_setpoint,
	input logic signed [DRV_W-1:0]  left_drive,
	input logic signed [DRV_W-1:0]  right_drive,
	input logic                     profile_done
);

	// A stalled result word keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(velocity_setpoint)
			&& $stable(left_drive) && $stable(profile_done))
		else $error("result word changed while stalled");

	// The last point of a move, and an idle tick, stand still.
	a_done_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && profile_done |-> velocity_setpoint == '0)
		else $error("nonzero velocity on a finished point");

	// At standstill the two sides steer symmetrically.
	a_done_sym: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && profile_done |-> DRV_W'(left_drive + right_drive) == '0)
		else $error("asymmetric drive at standstill");

	// A reverse move never reports a forward distance.
	a_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && velocity_setpoint[VEL_W-1]
			|-> distance_setpoint[DIST_W-1] || distance_setpoint == '0)
		else $error("distance sign disagrees with velocity");

endmodule

bind trapezoid_motion_profile_core tmpg_checker u_tmpg_checker (.*);
